// ===== hw/rtl/clfv_pkg.sv =====
package clfv_pkg;

    // Fixed field widths of the request and result words
    localparam int REQ_TYPE_W  = 2;
    localparam int SET_IDX_W   = 6;
    localparam int WAY_IDX_W   = 3;
    localparam int NOW_W       = 32;
    localparam int DIRTY_W     = 8;
    localparam int VICTIM_W    = 3;

    // Defaults for the top-level parameters
    localparam int DEF_NUM_SETS   = 64;
    localparam int DEF_NUM_WAYS   = 8;
    localparam int DEF_STAMP_BITS = 32;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_TOUCH = 2'd0,
        REQ_FILL  = 2'd1,
        REQ_INVAL = 2'd2,
        REQ_QUERY = 2'd3
    } t_req_kind;

    // Pipeline control handed from the front end to the compare tree
    typedef struct packed {
        logic advance;   // whole pipe moves one step
        logic start;     // a query word was accepted this edge
    } t_pipe_ctl;

endpackage

// ===== hw/rtl/clfv_if.sv =====
interface clfv_req_if;
    logic                           valid;
    logic                           ready;
    logic [clfv_pkg::REQ_TYPE_W-1:0] req_type;
    logic [clfv_pkg::SET_IDX_W-1:0]  set_index;
    logic [clfv_pkg::WAY_IDX_W-1:0]  way_index;
    logic [clfv_pkg::NOW_W-1:0]      now;
    logic [clfv_pkg::DIRTY_W-1:0]    dirty_mask;

    modport source (
        output valid, req_type, set_index, way_index, now, dirty_mask,
        input  ready
    );
    modport sink (
        input  valid, req_type, set_index, way_index, now, dirty_mask,
        output ready
    );
endinterface

interface clfv_res_if;
    logic                          valid;
    logic                          ready;
    logic [clfv_pkg::VICTIM_W-1:0] victim_way;
    logic                          victim_is_dirty;

    modport source (
        output valid, victim_way, victim_is_dirty,
        input  ready
    );
    modport sink (
        input  valid, victim_way, victim_is_dirty,
        output ready
    );
endinterface

// ===== hw/rtl/clean_first_lru_victim_select.sv =====
// Clean-first LRU victim selection. Stamps for every way of every set live in
// one row-wide synchronous memory, a set per row. Touch, fill and invalidate
// words are taken one per cycle while the result side keeps up and write their
// way's stamp at once; a victim query reads the set's row and walks it through
// a registered compare tree, its row registered out of the memory and then at
// each tree level, with a new word accepted every cycle while the result side
// keeps up. A stall on the result side holds the whole pipe. After reset the
// block zeroes the stamp memory a row at a time and accepts no word until that
// is done. Set numbers wrap modulo NUM_SETS; way numbers at or above NUM_WAYS
// make a write a no-op.
module clean_first_lru_victim_select #(
    parameter int NUM_SETS   = clfv_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS   = clfv_pkg::DEF_NUM_WAYS,
    parameter int STAMP_BITS = clfv_pkg::DEF_STAMP_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    clfv_req_if.sink          i_req,
    clfv_res_if.source        o_res
);

    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_SPAN = 1 << clfv_pkg::SET_IDX_W;

    logic                 r_clr_busy;
    logic [SET_W-1:0]     r_clr_addr;
    logic                 n_clr_busy;
    logic [SET_W-1:0]     n_clr_addr;

    logic                 advance;
    logic                 accept;
    logic                 is_query;
    clfv_pkg::t_pipe_ctl  ctl;

    logic [SET_W-1:0]     set_map [SET_SPAN];
    logic [SET_W-1:0]     set_sel;
    logic [NUM_WAYS-1:0]  way_hit;
    logic [NUM_WAYS-1:0]  dirty_w;
    logic [NUM_WAYS-1:0]  we;
    logic [SET_W-1:0]     waddr;
    logic [STAMP_BITS-1:0] wstamp;

    logic [NUM_WAYS-1:0][STAMP_BITS-1:0] rrow;
    logic                 tree_valid;
    logic [WAY_W-1:0]     tree_way;
    logic                 tree_dirty;
    logic [clfv_pkg::VICTIM_W+WAY_W-1:0] way_ext;

    // Set number wrap, worked out at elaboration
    for (genvar k = 0; k < SET_SPAN; k++) begin : g_set_map
        assign set_map[k] = SET_W'(k % NUM_SETS);
    end

    for (genvar w = 0; w < NUM_WAYS; w++) begin : g_way
        assign way_hit[w] = (32'(i_req.way_index) == w);
        if (w < clfv_pkg::DIRTY_W) begin : g_mask
            assign dirty_w[w] = i_req.dirty_mask[w];
        end else begin : g_clean
            assign dirty_w[w] = 1'b0;
        end
    end

    assign set_sel  = set_map[i_req.set_index];
    assign advance  = !tree_valid || o_res.ready;
    assign i_req.ready = advance && !r_clr_busy;
    assign accept   = i_req.valid && i_req.ready;
    assign is_query = (clfv_pkg::t_req_kind'(i_req.req_type) == clfv_pkg::REQ_QUERY);

    assign ctl.advance = advance;
    assign ctl.start   = accept && is_query;

    // Clearing pass after reset, one row a cycle
    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_addr = r_clr_addr;
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_comb begin
        if (r_clr_busy) begin
            we     = '1;
            waddr  = r_clr_addr;
            wstamp = '0;
        end else begin
            we     = (accept && !is_query) ? way_hit : '0;
            waddr  = set_sel;
            if (clfv_pkg::t_req_kind'(i_req.req_type) == clfv_pkg::REQ_INVAL) begin
                wstamp = '0;
            end else begin
                wstamp = STAMP_BITS'(i_req.now);
            end
        end
    end

    clfv_stamp_ram #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) u_ram (
        .i_clk    (i_clk),
        .i_we     (we),
        .i_waddr  (waddr),
        .i_wstamp (wstamp),
        .i_re     (ctl.start),
        .i_raddr  (set_sel),
        .o_rrow   (rrow)
    );

    clfv_min_tree #(
        .NUM_WAYS   (NUM_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_dirty (dirty_w),
        .i_row   (rrow),
        .o_valid (tree_valid),
        .o_way   (tree_way),
        .o_dirty (tree_dirty)
    );

    assign way_ext               = {{clfv_pkg::VICTIM_W{1'b0}}, tree_way};
    assign o_res.valid           = tree_valid;
    assign o_res.victim_way      = way_ext[clfv_pkg::VICTIM_W-1:0];
    assign o_res.victim_is_dirty = tree_dirty;

endmodule

// ===== hw/rtl/clfv_stamp_ram.sv =====
module clfv_stamp_ram #(
    parameter int NUM_SETS   = clfv_pkg::DEF_NUM_SETS,
    parameter int NUM_WAYS   = clfv_pkg::DEF_NUM_WAYS,
    parameter int STAMP_BITS = clfv_pkg::DEF_STAMP_BITS,
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
    input  logic                                i_clk,
    input  logic [NUM_WAYS-1:0]                 i_we,
    input  logic [SET_W-1:0]                    i_waddr,
    input  logic [STAMP_BITS-1:0]               i_wstamp,
    input  logic                                i_re,
    input  logic [SET_W-1:0]                    i_raddr,
    output logic [NUM_WAYS-1:0][STAMP_BITS-1:0] o_rrow
);

    // One row per set, one stamp lane per way with its own write enable
    logic [NUM_WAYS-1:0][STAMP_BITS-1:0] mem [NUM_SETS];
    logic [NUM_WAYS-1:0][STAMP_BITS-1:0] r_rrow;

    always_ff @(posedge i_clk) begin
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (i_we[w]) begin
                mem[i_waddr][w] <= i_wstamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rrow <= mem[i_raddr];
        end
    end

    assign o_rrow = r_rrow;

endmodule

// ===== hw/rtl/clfv_min_tree.sv =====
module clfv_min_tree #(
    parameter int NUM_WAYS   = clfv_pkg::DEF_NUM_WAYS,
    parameter int STAMP_BITS = clfv_pkg::DEF_STAMP_BITS,
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  clfv_pkg::t_pipe_ctl                 i_ctl,
    input  logic [NUM_WAYS-1:0]                 i_dirty,
    input  logic [NUM_WAYS-1:0][STAMP_BITS-1:0] i_row,
    output logic                                o_valid,
    output logic [WAY_W-1:0]                    o_way,
    output logic                                o_dirty
);

    localparam int LEVELS = $clog2(NUM_WAYS);
    localparam int SPAN   = 1 << LEVELS;
    // Dirty bit on top: clean ways always order below dirty ones
    localparam int KEY_W  = STAMP_BITS + 1;

    logic [KEY_W-1:0] lvl_key [LEVELS+1][SPAN];
    logic [WAY_W-1:0] lvl_idx [LEVELS+1][SPAN];
    logic             lvl_ok  [LEVELS+1][SPAN];
    logic             lvl_vld [LEVELS+1];

    logic                r_vld0;
    logic [NUM_WAYS-1:0] r_dirty0;

    // Level 0 lines up with the registered memory row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_ctl.advance) begin
            r_vld0 <= i_ctl.start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dirty0 <= i_dirty;
        end
    end

    assign lvl_vld[0] = r_vld0;

    for (genvar i = 0; i < SPAN; i++) begin : g_leaf
        if (i < NUM_WAYS) begin : g_real
            assign lvl_key[0][i] = {r_dirty0[i], i_row[i]};
            assign lvl_ok[0][i]  = 1'b1;
        end else begin : g_pad
            assign lvl_key[0][i] = '0;
            assign lvl_ok[0][i]  = 1'b0;
        end
        assign lvl_idx[0][i] = WAY_W'(i);
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int CNT = SPAN >> l;

        logic [KEY_W-1:0] r_key [CNT];
        logic [WAY_W-1:0] r_idx [CNT];
        logic             r_ok  [CNT];
        logic             r_vld;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.advance) begin
                r_vld <= lvl_vld[l-1];
            end
        end

        // Left wins ties: it always holds the lower way numbers
        always_ff @(posedge i_clk) begin
            if (i_ctl.advance) begin
                for (int i = 0; i < CNT; i++) begin
                    if (lvl_ok[l-1][2*i] && (!lvl_ok[l-1][2*i+1] ||
                            lvl_key[l-1][2*i] <= lvl_key[l-1][2*i+1])) begin
                        r_key[i] <= lvl_key[l-1][2*i];
                        r_idx[i] <= lvl_idx[l-1][2*i];
                        r_ok[i]  <= 1'b1;
                    end else begin
                        r_key[i] <= lvl_key[l-1][2*i+1];
                        r_idx[i] <= lvl_idx[l-1][2*i+1];
                        r_ok[i]  <= lvl_ok[l-1][2*i+1];
                    end
                end
            end
        end

        assign lvl_vld[l] = r_vld;

        for (genvar i = 0; i < SPAN; i++) begin : g_node
            if (i < CNT) begin : g_used
                assign lvl_key[l][i] = r_key[i];
                assign lvl_idx[l][i] = r_idx[i];
                assign lvl_ok[l][i]  = r_ok[i];
            end else begin : g_idle
                assign lvl_key[l][i] = '0;
                assign lvl_idx[l][i] = '0;
                assign lvl_ok[l][i]  = 1'b0;
            end
        end
    end

    assign o_valid = lvl_vld[LEVELS];
    assign o_way   = lvl_idx[LEVELS][0];
    assign o_dirty = lvl_key[LEVELS][0][KEY_W-1];

endmodule

// ===== test/clean_first_lru_victim_select_test.sv =====
module clean_first_lru_victim_select_test;

    localparam int NUM_SETS     = clfv_pkg::DEF_NUM_SETS;
    localparam int NUM_WAYS     = clfv_pkg::DEF_NUM_WAYS;
    localparam int STAMP_BITS   = clfv_pkg::DEF_STAMP_BITS;
    localparam int RANDOM_WORDS = 1630;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam logic [15:0] READY_PATTERN = 16'b1011_0010_1110_0101;

    typedef struct {
        clfv_pkg::t_req_kind             kind;
        logic [clfv_pkg::SET_IDX_W-1:0]  set_idx;
        logic [clfv_pkg::WAY_IDX_W-1:0]  way_idx;
        logic [clfv_pkg::NOW_W-1:0]      stamp_now;
        logic [clfv_pkg::DIRTY_W-1:0]    dirty;
        bit                              typed;      // victim given in the row
        logic [clfv_pkg::VICTIM_W-1:0]   typed_way;
        bit                              typed_dirty;
        bit                              hold;       // wait for every result first
    } t_access;

    typedef struct {
        logic [clfv_pkg::VICTIM_W-1:0] way;
        logic                          dirty;
    } t_victim;

    logic i_clk;
    logic i_rst_n;

    clfv_req_if req_ch ();
    clfv_res_if res_ch ();

    clean_first_lru_victim_select #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .STAMP_BITS (STAMP_BITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    logic [STAMP_BITS-1:0] stamp_mem [NUM_SETS][NUM_WAYS];
    t_access               access_q [$];
    t_victim               victim_q [$];
    t_access               directed_rows [23];
    int unsigned           cycle_count = 0;
    int                    burst_left = 0;
    int                    gap_left = 0;
    bit                    failed = 1'b0;

    function automatic t_victim pick_victim(input t_access a);
        int      set_no;
        int      lru_way;
        int      clean_way;
        bit      have_clean;
        bit      is_dirty;
        t_victim v;
        set_no     = a.set_idx % NUM_SETS;
        lru_way    = 0;
        clean_way  = 0;
        have_clean = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            is_dirty = (w < clfv_pkg::DIRTY_W) ? a.dirty[w] : 1'b0;
            if (stamp_mem[set_no][w] < stamp_mem[set_no][lru_way])
                lru_way = w;
            if (!is_dirty && (!have_clean ||
                    stamp_mem[set_no][w] < stamp_mem[set_no][clean_way])) begin
                clean_way  = w;
                have_clean = 1'b1;
            end
        end
        v.way   = clfv_pkg::VICTIM_W'(have_clean ? clean_way : lru_way);
        v.dirty = !have_clean;
        return v;
    endfunction

    // Applies one accepted word to the stamp store; queries queue a victim.
    function automatic void track_access(input t_access a);
        t_victim v;
        int      set_no;
        set_no = a.set_idx % NUM_SETS;
        if (a.kind == clfv_pkg::REQ_QUERY) begin
            if (a.typed) begin
                v.way   = a.typed_way;
                v.dirty = a.typed_dirty;
            end else begin
                v = pick_victim(a);
            end
            victim_q.push_back(v);
        end else if (a.way_idx < NUM_WAYS) begin
            stamp_mem[set_no][a.way_idx] = (a.kind == clfv_pkg::REQ_INVAL) ? '0 :
                                           STAMP_BITS'(a.stamp_now);
        end
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // Sender: bursts of words with random gaps; valid held until taken.
    always @(posedge i_clk) begin
        t_access cur;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                cur = access_q.pop_front();
                track_access(cur);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                    gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            end
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (burst_left == 0 && gap_left > 0) begin
                    gap_left--;
                    req_ch.valid <= 1'b0;
                end else begin
                    if (burst_left == 0)
                        burst_left = ($urandom_range(7) == 0) ? 80 : $urandom_range(1, 12);
                    if (access_q.size() != 0 &&
                            (!access_q[0].hold || victim_q.size() == 0)) begin
                        req_ch.valid      <= 1'b1;
                        req_ch.req_type   <= access_q[0].kind;
                        req_ch.set_index  <= access_q[0].set_idx;
                        req_ch.way_index  <= access_q[0].way_idx;
                        req_ch.now        <= access_q[0].stamp_now;
                        req_ch.dirty_mask <= access_q[0].dirty;
                    end else begin
                        req_ch.valid <= 1'b0;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern changes with cycle_count bits 9:8.
    always @(posedge i_clk) begin
        t_victim want;
        if (res_ch.valid && res_ch.ready) begin
            if (victim_q.size() == 0) begin
                $error("victim word with no query outstanding: way %0d dirty %0d",
                       res_ch.victim_way, res_ch.victim_is_dirty);
                failed = 1'b1;
            end else begin
                want = victim_q.pop_front();
                if (res_ch.victim_way !== want.way) begin
                    $error("victim_way: expected %0d, got %0d", want.way, res_ch.victim_way);
                    failed = 1'b1;
                end
                if (res_ch.victim_is_dirty !== want.dirty) begin
                    $error("victim_is_dirty: expected %0d, got %0d",
                           want.dirty, res_ch.victim_is_dirty);
                    failed = 1'b1;
                end
            end
        end
        case (cycle_count[9:8])
            2'd0:    res_ch.ready <= 1'b1;
            2'd1:    res_ch.ready <= READY_PATTERN[cycle_count[3:0]];
            2'd2:    res_ch.ready <= ($urandom_range(3) != 0);
            default: res_ch.ready <= (cycle_count[4:0] >= 5'd20);
        endcase
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_access                    a;
        int                         pick;
        logic [clfv_pkg::NOW_W-1:0] stamp_clock;

        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = clfv_pkg::REQ_TOUCH;
        req_ch.set_index  = '0;
        req_ch.way_index  = '0;
        req_ch.now        = '0;
        req_ch.dirty_mask = '0;
        res_ch.ready      = 1'b0;
        foreach (stamp_mem[s, w])
            stamp_mem[s][w] = '0;

        // kind, set, way, now, dirty, typed, way, dirty, hold
        directed_rows = '{
            // cleared store: all ties, lowest clean or lowest overall
            '{clfv_pkg::REQ_QUERY, 6'd0,  3'd0, 32'h0000_0000, 8'h00, 1'b1, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd63, 3'd7, 32'hFFFF_FFFF, 8'hFF, 1'b1, 3'd0, 1'b1, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd7,  3'd0, 32'h0000_0000, 8'h7F, 1'b1, 3'd7, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd7,  3'd0, 32'h0000_0000, 8'hFE, 1'b1, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd63, 3'd0, 32'hFFFF_FFFF, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_TOUCH, 6'd63, 3'd1, 32'h0000_0000, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd63, 3'd0, 32'h0000_0000, 8'hFF, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd63, 3'd0, 32'h0000_0000, 8'h01, 1'b0, 3'd0, 1'b0, 1'b0},
            // out-of-order stamps, top bit set on some
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd0, 32'h8000_0000, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd1, 32'h0000_0010, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd2, 32'hFFFF_FFFE, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd3, 32'h0000_0010, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd4, 32'h0000_0005, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd5, 32'h0000_0009, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd6, 32'h7FFF_FFFF, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_FILL,  6'd20, 3'd7, 32'h0000_0030, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd20, 3'd0, 32'h0000_0000, 8'hFF, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd20, 3'd0, 32'h0000_0000, 8'h10, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_INVAL, 6'd20, 3'd6, 32'hFFFF_FFFF, 8'hFF, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd20, 3'd0, 32'h0000_0000, 8'hBF, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_TOUCH, 6'd20, 3'd6, 32'hFFFF_FFFF, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd20, 3'd0, 32'h0000_0000, 8'h00, 1'b0, 3'd0, 1'b0, 1'b0},
            '{clfv_pkg::REQ_QUERY, 6'd20, 3'd5, 32'h1234_5678, 8'h3A, 1'b0, 3'd0, 1'b0, 1'b0}
        };
        foreach (directed_rows[i])
            access_q.push_back(directed_rows[i]);

        // Random part: mostly a few hot sets and a slowly rising clock, so
        // rows fill up and ties happen.
        stamp_clock = 32'h0000_0100;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            pick = $urandom_range(99);
            a.kind = (pick < 45) ? clfv_pkg::REQ_QUERY :
                     (pick < 70) ? clfv_pkg::REQ_FILL :
                     (pick < 90) ? clfv_pkg::REQ_TOUCH : clfv_pkg::REQ_INVAL;
            a.set_idx = ($urandom_range(3) == 0) ? clfv_pkg::SET_IDX_W'($urandom) :
                        clfv_pkg::SET_IDX_W'($urandom_range(3) * 21);
            a.way_idx = clfv_pkg::WAY_IDX_W'($urandom_range(7));
            case ($urandom_range(9))
                0: a.stamp_now = $urandom;
                1: a.stamp_now = $urandom_range(1) ? '1 : '0;
                2: begin
                    stamp_clock += $urandom;
                    a.stamp_now = stamp_clock;
                end
                default: begin
                    stamp_clock += $urandom_range(2);
                    a.stamp_now = stamp_clock;
                end
            endcase
            case ($urandom_range(5))
                0:       a.dirty = '1;
                1:       a.dirty = '0;
                2:       a.dirty = ~(clfv_pkg::DIRTY_W'(1) <<
                                     $urandom_range(clfv_pkg::DIRTY_W - 1));
                default: a.dirty = clfv_pkg::DIRTY_W'($urandom);
            endcase
            a.typed       = 1'b0;
            a.typed_way   = '0;
            a.typed_dirty = 1'b0;
            a.hold        = (i == 0 || i == RANDOM_WORDS / 2);
            access_q.push_back(a);
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (access_q.size() == 0 && victim_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== clean_first_lru_victim_select.f =====
hw/rtl/clfv_pkg.sv
hw/rtl/clfv_if.sv
hw/rtl/clfv_stamp_ram.sv
hw/rtl/clfv_min_tree.sv
hw/rtl/clean_first_lru_victim_select.sv
test/clean_first_lru_victim_select_test.sv
